>>> sv/pvz_pkg.sv
// ----------------------------------------------------------------------------
// pvz_pkg: shared types and constants of the prefix varint zigzag codec
// Holds the request and response item types, the command and result codes,
// the length prefixes and the zigzag mapping functions.
// ----------------------------------------------------------------------------
package pvz_pkg;

    // Command codes of a request item.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Result codes of a response item.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // Length prefixes held in the top two bits of a first byte.
    localparam logic [1:0] PFX_ONE   = 2'b00;
    localparam logic [1:0] PFX_TWO   = 2'b01;
    localparam logic [1:0] PFX_THREE = 2'b10;
    localparam logic [1:0] PFX_FIVE  = 2'b11;

    // Full first-byte forms of the prefixes.
    localparam logic [7:0] PFX_TWO_BYTE   = 8'h40;
    localparam logic [7:0] PFX_THREE_BYTE = 8'h80;
    localparam logic [7:0] PFX_FIVE_BYTE  = 8'hc0;

    // Largest value that fits each short length.
    localparam logic [31:0] MAX_ONE   = 32'h0000_003f;
    localparam logic [31:0] MAX_TWO   = 32'h0000_3fff;
    localparam logic [31:0] MAX_THREE = 32'h003f_ffff;

    // Request item.
    typedef struct packed {
        logic        cmd;
        logic [31:0] value_in;
        logic        zigzag;
        logic [7:0]  byte_in;
    } req_item_t;

    // Response item.
    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_out;
        logic        byte_last;
        logic [31:0] value_out;
    } rsp_item_t;

    // Control from the top level into the decoder.
    typedef struct packed {
        logic       fire;
        logic       first_zig;
        logic [7:0] data;
    } dec_ctl_t;

    // Status from the decoder back to the top level.
    typedef struct packed {
        logic        produce;
        logic [31:0] value;
    } dec_sts_t;

    // Zigzag map: sign moves to the low bit.
    function automatic logic [31:0] zz_map(input logic [31:0] v);
        zz_map = {v[30:0], 1'b0} ^ {32{v[31]}};
    endfunction

    // Zigzag unmap: inverse of zz_map.
    function automatic logic [31:0] zz_unmap(input logic [31:0] v);
        zz_unmap = {1'b0, v[31:1]} ^ {32{v[0]}};
    endfunction

endpackage

>>> sv/prefix_varint_zigzag_codec.sv
// ----------------------------------------------------------------------------
// prefix_varint_zigzag_codec: prefix-length varint codec with zigzag option
// Encode requests produce one to five bytes; decode requests take one byte
// each and produce a value once its encoding is complete.
// ----------------------------------------------------------------------------
//  Channel  Signals                        Moves
//  req      req_valid/req_ready/req_data   one request word (encode or byte)
//  rsp      rsp_valid/rsp_ready/rsp_data   one response word (byte or value)
//
// A request word lands in a holding register and its results go to the
// response register in the following cycles, one word per cycle unless the
// response stalls. Decode words pass at one per cycle, but one finishing a
// value waits for a free response; an encode word stays for its 1, 2, 3 or
// 5 bytes, set by the byte counter. Reset clears both valid flags, the byte
// counter and the decoder state. A word held by a stalled response drops req_ready.
// ----------------------------------------------------------------------------
module prefix_varint_zigzag_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pvz_pkg::req_item_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pvz_pkg::rsp_item_t rsp_data
);
    import pvz_pkg::*;

    logic      hold_valid_reg, hold_valid_next;
    req_item_t hold_reg;
    logic [2:0] idx_reg, idx_next;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_reg, rsp_next;

    logic      out_free;
    logic      is_enc;
    logic      is_dec;
    logic [7:0] enc_byte;
    logic      enc_last;
    dec_ctl_t  dec_ctl;
    dec_sts_t  dec_sts;
    logic      load_out;
    logic      step_done;

    // Byte selector for the held encode word.
    pvz_enc u_enc (
        .value  (hold_reg.value_in),
        .zigzag (hold_reg.zigzag),
        .idx    (idx_reg),
        .data   (enc_byte),
        .last   (enc_last)
    );

    // Decoder; its state moves only on decode words.
    pvz_dec u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dec_ctl),
        .sts   (dec_sts)
    );

    // Step control for the held word.
    always_comb
    begin
        out_free  = !rsp_valid_reg || rsp_ready;
        is_enc    = hold_valid_reg && (hold_reg.cmd == CMD_ENCODE);
        is_dec    = hold_valid_reg && (hold_reg.cmd == CMD_DECODE);

        dec_ctl.first_zig = hold_reg.zigzag;
        dec_ctl.data      = hold_reg.byte_in;
        dec_ctl.fire      = is_dec && (!dec_sts.produce || out_free);

        load_out  = out_free && (is_enc || (is_dec && dec_sts.produce));
        step_done = (is_enc && out_free && enc_last) || dec_ctl.fire;
        req_ready = !hold_valid_reg || step_done;
    end

    // Next holding register flag and byte counter.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (req_valid && req_ready)
            hold_valid_next = 1'b1;
        else if (step_done)
            hold_valid_next = 1'b0;

        idx_next = idx_reg;
        if (is_enc && out_free)
            idx_next = enc_last ? 3'd0 : idx_reg + 3'd1;
    end

    // Next response word.
    always_comb
    begin
        rsp_next = rsp_reg;
        if (load_out)
        begin
            if (is_enc)
            begin
                rsp_next.kind      = KIND_BYTE;
                rsp_next.byte_out  = enc_byte;
                rsp_next.byte_last = enc_last;
                rsp_next.value_out = 32'd0;
            end
            else
            begin
                rsp_next.kind      = KIND_VALUE;
                rsp_next.byte_out  = 8'd0;
                rsp_next.byte_last = 1'b0;
                rsp_next.value_out = dec_sts.value;
            end
        end
        rsp_valid_next = load_out || (rsp_valid_reg && !rsp_ready);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 3'd0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            hold_reg <= req_data;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // The byte counter never passes the fifth byte.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 3'd4)
        else $error("encode byte counter out of range");

    // A byte counter in mid-word implies an encode word is held.
    a_idx_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> (hold_valid_reg && (hold_reg.cmd == CMD_ENCODE)))
        else $error("byte counter running without an encode word");

    // A held word that cannot finish stays in place.
    a_hold_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !req_ready) |=> (hold_valid_reg && $stable(hold_reg)))
        else $error("held word lost while stalled");

endmodule

>>> sv/pvz_enc.sv
// ----------------------------------------------------------------------------
// pvz_enc: encoded byte selector
// Maps a value (optionally zigzag first) to its 1, 2, 3 or 5 byte encoding
// and returns the byte at the given position with its last-byte mark.
// ----------------------------------------------------------------------------
module pvz_enc (
    input  logic [31:0] value,
    input  logic        zigzag,
    input  logic [2:0]  idx,
    output logic [7:0]  data,
    output logic        last
);
    import pvz_pkg::*;

    logic [31:0] v;
    logic [7:0]  bytes [5];
    logic [2:0]  last_idx;

    // Apply the zigzag mapping when asked for.
    assign v = zigzag ? zz_map(value) : value;

    // Build the byte sequence for the length the value needs.
    always_comb
    begin
        bytes[0] = PFX_FIVE_BYTE;
        bytes[1] = v[31:24];
        bytes[2] = v[23:16];
        bytes[3] = v[15:8];
        bytes[4] = v[7:0];
        last_idx = 3'd4;
        priority if (v <= MAX_ONE)
        begin
            bytes[0] = v[7:0];
            last_idx = 3'd0;
        end
        else if (v <= MAX_TWO)
        begin
            bytes[0] = PFX_TWO_BYTE | {2'b00, v[13:8]};
            bytes[1] = v[7:0];
            last_idx = 3'd1;
        end
        else if (v <= MAX_THREE)
        begin
            bytes[0] = PFX_THREE_BYTE | {2'b00, v[21:16]};
            bytes[1] = v[15:8];
            bytes[2] = v[7:0];
            last_idx = 3'd2;
        end
        else
        begin
            last_idx = 3'd4;
        end
    end

    // Pick the requested byte; positions past the end never get asked for.
    always_comb
    begin
        data = bytes[4];
        unique case (idx)
            3'd0:    data = bytes[0];
            3'd1:    data = bytes[1];
            3'd2:    data = bytes[2];
            3'd3:    data = bytes[3];
            default: data = bytes[4];
        endcase
    end

    assign last = (idx == last_idx);

endmodule

>>> sv/pvz_dec.sv
// ----------------------------------------------------------------------------
// pvz_dec: byte-at-a-time decoder
// Holds the count of owed bytes, the gathered value bits and the zigzag
// flag, and reports a finished value on the byte that completes it.
// ----------------------------------------------------------------------------
module pvz_dec (
    input  logic             clk,
    input  logic             rst_n,
    input  pvz_pkg::dec_ctl_t ctl,
    output pvz_pkg::dec_sts_t sts
);
    import pvz_pkg::*;

    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [31:0] acc_reg, acc_next;
    logic        signed_reg, signed_next;

    // Next decoder state for the byte on offer.
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        signed_next     = signed_reg;
        sts.produce     = 1'b0;
        if (bytes_left_reg == 3'd0)
        begin
            signed_next = ctl.first_zig;
            unique case (ctl.data[7:6])
                PFX_ONE:
                begin
                    acc_next    = {24'd0, ctl.data};
                    sts.produce = 1'b1;
                end
                PFX_TWO:
                begin
                    acc_next        = {26'd0, ctl.data[5:0]};
                    bytes_left_next = 3'd1;
                end
                PFX_THREE:
                begin
                    acc_next        = {26'd0, ctl.data[5:0]};
                    bytes_left_next = 3'd2;
                end
                default:
                begin
                    acc_next        = 32'd0;
                    bytes_left_next = 3'd4;
                end
            endcase
        end
        else
        begin
            acc_next        = {acc_reg[23:0], ctl.data};
            bytes_left_next = bytes_left_reg - 3'd1;
            sts.produce     = (bytes_left_reg == 3'd1);
        end
    end

    // Finished value, with the zigzag mapping undone if it was latched.
    assign sts.value = signed_next ? zz_unmap(acc_next) : acc_next;

    // State registers advance only when the top level takes the byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 3'd0;
            acc_reg        <= 32'd0;
            signed_reg     <= 1'b0;
        end
        else if (ctl.fire)
        begin
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            signed_reg     <= signed_next;
        end
    end

    // The owed-byte count is only ever 0, 1, 2, 4 or counting down from 4.
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= 3'd4)
        else $error("decoder byte count out of range");

    // A value completes exactly when the last owed byte is taken.
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fire && sts.produce) |=> (bytes_left_reg == 3'd0))
        else $error("decoder finished with bytes still owed");

endmodule

>>> verif/prefix_varint_zigzag_codec_tb.sv
// ----------------------------------------------------------------------------
// prefix_varint_zigzag_codec_tb: self-checking bench for the varint codec
// Walks a short table of directed words (length boundaries, zigzag extremes,
// the five-byte marker, non-minimal encodings, encodes interleaved with a
// decode), then random encodes, well-formed decode streams and stray bytes.
// Both channels idle at random. Every response word is checked against a
// hand-typed word or a behavioral predictor of the codec kept in this bench.
// ----------------------------------------------------------------------------
module prefix_varint_zigzag_codec_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pvz_pkg::*;

    localparam int RAND_WORDS  = 335;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_TAIL  = 10;
    localparam int SHOWN_FAILS = 10;

    // One row of the directed table: a request, and the single response
    // word typed in by hand when it is obvious.
    typedef struct packed {
        req_item_t req;
        logic      known;
        rsp_item_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req_data;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp_data;

    // Decoder state of the predictor.
    logic [2:0]  dec_left;
    logic [31:0] dec_acc;
    logic        dec_zig;

    rsp_item_t due_words[$];
    dir_row_t  dir_tab[$];
    int        fail_count  = 0;
    int        items_sent  = 0;
    int        words_seen  = 0;
    int        idle_cycles = 0;
    int        stall_left  = 0;
    bit        calm        = 1'b0;

    prefix_varint_zigzag_codec u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Zigzag fold of a signed pattern, and its inverse.
    function automatic logic [31:0] zz_fold(input logic [31:0] v);
        return (v << 1) ^ {32{v[31]}};
    endfunction

    function automatic logic [31:0] zz_unfold(input logic [31:0] v);
        return (v >> 1) ^ {32{v[0]}};
    endfunction

    // Shortest encoded length of a value.
    function automatic int code_len(input logic [31:0] v);
        if (v <= MAX_ONE)
            return 1;
        if (v <= MAX_TWO)
            return 2;
        if (v <= MAX_THREE)
            return 3;
        return 5;
    endfunction

    // Byte i of the n-byte encoding of v, most significant first.
    function automatic logic [7:0] code_byte(input logic [31:0] v, input int n,
                                             input int i);
        logic [31:0] s;
        if (n == 5 && i == 0)
            return PFX_FIVE_BYTE;
        s = v >> (8 * (n - 1 - i));
        if (i != 0)
            return s[7:0];
        case (n)
            1:       return {PFX_ONE, s[5:0]};
            2:       return {PFX_TWO, s[5:0]};
            default: return {PFX_THREE, s[5:0]};
        endcase
    endfunction

    function automatic req_item_t enc_req(input logic [31:0] v, input logic zig);
        req_item_t r;
        r.cmd      = CMD_ENCODE;
        r.value_in = v;
        r.zigzag   = zig;
        r.byte_in  = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic req_item_t dec_req(input logic [7:0] b, input logic zig);
        req_item_t r;
        r.cmd      = CMD_DECODE;
        r.value_in = $urandom();
        r.zigzag   = zig;
        r.byte_in  = b;
        return r;
    endfunction

    function automatic rsp_item_t byte_word(input logic [7:0] b, input logic last);
        rsp_item_t w;
        w.kind      = KIND_BYTE;
        w.byte_out  = b;
        w.byte_last = last;
        w.value_out = '0;
        return w;
    endfunction

    function automatic rsp_item_t val_word(input logic [31:0] v);
        rsp_item_t w;
        w.kind      = KIND_VALUE;
        w.byte_out  = '0;
        w.byte_last = 1'b0;
        w.value_out = v;
        return w;
    endfunction

    function automatic dir_row_t tab_row(input req_item_t r, input logic known,
                                         input rsp_item_t w);
        dir_row_t d;
        d.req   = r;
        d.known = known;
        d.want  = w;
        return d;
    endfunction

    // Value picker: each length class, full range, and the boundaries.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, MAX_ONE);
            1: return $urandom_range(MAX_ONE + 1, MAX_TWO);
            2: return $urandom_range(MAX_TWO + 1, MAX_THREE);
            3, 4: return $urandom();
            default:
            begin
                case ($urandom_range(0, 9))
                    0: return 32'h0;
                    1: return MAX_ONE;
                    2: return MAX_ONE + 1;
                    3: return MAX_TWO;
                    4: return MAX_TWO + 1;
                    5: return MAX_THREE;
                    6: return MAX_THREE + 1;
                    7: return 32'h7fff_ffff;
                    8: return 32'h8000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    // Idle length: mostly none or short, a few long, none in calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Value finished by the decoder, with the zigzag undone if it was asked.
    function automatic logic [31:0] decoded_value();
        return dec_zig ? zz_unfold(dec_acc) : dec_acc;
    endfunction

    // Predictor: advances the decoder state for one accepted request and,
    // when post is set, queues the response words it causes.
    task automatic compute_words(input req_item_t w, input bit post);
        logic [31:0] v;
        int          n;
        int          i;
        if (w.cmd == CMD_ENCODE)
        begin
            v = w.zigzag ? zz_fold(w.value_in) : w.value_in;
            n = code_len(v);
            for (i = 0; i < n; i++)
                if (post)
                    due_words.push_back(byte_word(code_byte(v, n, i), i == n - 1));
        end
        else if (dec_left == 3'd0)
        begin
            dec_zig = w.zigzag;
            case (w.byte_in[7:6])
                PFX_ONE:
                begin
                    dec_acc = {24'h0, w.byte_in};
                    if (post)
                        due_words.push_back(val_word(decoded_value()));
                end
                PFX_TWO:
                begin
                    dec_acc  = {26'h0, w.byte_in[5:0]};
                    dec_left = 3'd1;
                end
                PFX_THREE:
                begin
                    dec_acc  = {26'h0, w.byte_in[5:0]};
                    dec_left = 3'd2;
                end
                default:
                begin
                    dec_acc  = '0;
                    dec_left = 3'd4;
                end
            endcase
        end
        else
        begin
            dec_acc  = {dec_acc[23:0], w.byte_in};
            dec_left = dec_left - 3'd1;
            if (dec_left == 3'd0 && post)
                due_words.push_back(val_word(decoded_value()));
        end
    endtask

    // Offer one request word, wait for it to be taken, then predict.
    task automatic send_word(input req_item_t w, input bit post);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        compute_words(w, post);
        items_sent++;
    endtask

    // Wait until every predicted response word has arrived.
    task automatic drain_words();
        req_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
    endtask

    // Response side: random back-pressure.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0 && pick_gap() > 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Response checker: each taken word against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            words_seen++;
            if (due_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOWN_FAILS)
                    $display("word %0d: unexpected kind=%0d byte=%02h last=%0d value=%08h",
                             words_seen, rsp_data.kind, rsp_data.byte_out,
                             rsp_data.byte_last, rsp_data.value_out);
            end
            else
            begin
                want = due_words.pop_front();
                if (rsp_data.kind !== want.kind || rsp_data.byte_out !== want.byte_out ||
                    rsp_data.byte_last !== want.byte_last ||
                    rsp_data.value_out !== want.value_out)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_FAILS)
                        $display({"word %0d: expected kind=%0d byte=%02h last=%0d ",
                                  "value=%08h, got kind=%0d byte=%02h last=%0d value=%08h"},
                                 words_seen, want.kind, want.byte_out, want.byte_last,
                                 want.value_out, rsp_data.kind, rsp_data.byte_out,
                                 rsp_data.byte_last, rsp_data.value_out);
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("prefix_varint_zigzag_codec test failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int          target;
        int          n;
        int          i;
        logic [31:0] v;
        logic        zig;
        int          r;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        dec_left  = '0;
        dec_acc   = '0;
        dec_zig   = 1'b0;

        // Directed table: results typed in where they are plain to see.
        dir_tab.push_back(tab_row(dec_req(8'h00, 1'b0), 1'b1, val_word(32'h0)));
        dir_tab.push_back(tab_row(dec_req(8'h3f, 1'b0), 1'b1, val_word(32'h3f)));
        dir_tab.push_back(tab_row(dec_req(8'h01, 1'b1), 1'b1, val_word(32'hffff_ffff)));
        dir_tab.push_back(tab_row(enc_req(32'h0, 1'b0), 1'b1, byte_word(8'h00, 1'b1)));
        dir_tab.push_back(tab_row(enc_req(MAX_ONE, 1'b0), 1'b1, byte_word(8'h3f, 1'b1)));
        dir_tab.push_back(tab_row(enc_req(32'hffff_ffff, 1'b1), 1'b1,
                                  byte_word(8'h01, 1'b1)));
        dir_tab.push_back(tab_row(enc_req(MAX_ONE + 1, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(enc_req(MAX_TWO, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(enc_req(MAX_TWO + 1, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(enc_req(MAX_THREE, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(enc_req(MAX_THREE + 1, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(enc_req(32'hffff_ffff, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(enc_req(32'h8000_0000, 1'b1), 1'b0, '0));
        dir_tab.push_back(tab_row(enc_req(32'h7fff_ffff, 1'b1), 1'b0, '0));
        // Five-byte marker with junk in its low bits, an encode in the middle,
        // and zigzag flags on later bytes that must be ignored.
        dir_tab.push_back(tab_row(dec_req(8'hff, 1'b1), 1'b0, '0));
        dir_tab.push_back(tab_row(enc_req(32'h1234_5678, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(dec_req(8'hff, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(dec_req(8'hff, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(dec_req(8'hff, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(dec_req(8'hfe, 1'b0), 1'b1, val_word(32'h7fff_ffff)));
        // Non-minimal encodings of small values.
        dir_tab.push_back(tab_row(dec_req(PFX_TWO_BYTE, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(dec_req(8'h05, 1'b1), 1'b1, val_word(32'h5)));
        dir_tab.push_back(tab_row(dec_req(PFX_THREE_BYTE, 1'b1), 1'b0, '0));
        dir_tab.push_back(tab_row(dec_req(8'h00, 1'b0), 1'b0, '0));
        dir_tab.push_back(tab_row(dec_req(8'h03, 1'b0), 1'b1, val_word(32'hffff_fffe)));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            send_word(dir_tab[k].req, !dir_tab[k].known);
            if (dir_tab[k].known)
                due_words.push_back(dir_tab[k].want);
        end

        // Hold the sender back until the codec has delivered everything.
        drain_words();

        // Random part: mostly well-formed decode streams and encodes.
        target = items_sent + RAND_WORDS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 11) == 0)
                calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                send_word(enc_req(pick_value(), 1'($urandom_range(0, 1))), 1'b1);
            end
            else if (r < 88)
            begin
                v   = pick_value();
                zig = 1'($urandom_range(0, 1));
                n   = code_len(v);
                if ($urandom_range(0, 4) == 0)
                    n = 5;
                for (i = 0; i < n; i++)
                begin
                    send_word(dec_req(code_byte(v, n, i),
                                      i == 0 ? zig : 1'($urandom_range(0, 1))), 1'b1);
                    if ($urandom_range(0, 5) == 0)
                        send_word(enc_req(pick_value(), 1'($urandom_range(0, 1))), 1'b1);
                end
            end
            else
            begin
                send_word(dec_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))),
                          1'b1);
            end
        end

        drain_words();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (fail_count == 0)
            $display("prefix_varint_zigzag_codec test passed");
        else
            $display("prefix_varint_zigzag_codec test failed");
        $finish;
    end

endmodule
